// ----- rtl/lpd_pkg.sv -----
// Shared types, constants and helpers for the length-prefix deframer.
// No dependencies; every rtl module imports this package.
package lpd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_CNT_W    = 3;
    localparam int LEN_W        = 32;
    localparam int MAX_LEN_W    = 24;
    localparam int POS_W        = 3;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'h01_0000;
    localparam logic [POS_W-1:0]     POS_SAT       = 3'd4;
    localparam logic [POS_W-1:0]     POS_CTRL_LAST = 3'd3;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_PING  = 2'd2,
        KIND_PONG  = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        frame_kind_t frame_kind;
        logic        protocol_error;
    } result_t;

    // Byte idx of the ASCII word "PING" (is_pong = 0) or "PONG" (is_pong = 1).
    function automatic logic [7:0] ctrl_byte(input logic is_pong, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            2'd0: b = 8'h50;
            2'd1: b = is_pong ? 8'h4F : 8'h49;
            2'd2: b = 8'h4E;
            2'd3: b = 8'h47;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lpd_front.sv -----
// Front end of the deframer: takes bytes, tracks header and payload state
// and produces one classified result per byte that causes one. Uses lpd_pkg.
module lpd_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic [7:0]                            rx_byte,
    input  logic                                  cfg_wr_en,
    input  logic [lpd_pkg::MAX_LEN_W-1:0]         cfg_wr_data,
    output logic                                  push,
    output lpd_pkg::result_t                      push_data
);
    import lpd_pkg::*;

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]     accum_reg, accum_next;
    logic [MAX_LEN_W-1:0] remain_reg, remain_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 ping_reg, ping_next;
    logic                 pong_reg, pong_next;
    logic                 closed_reg, closed_next;
    logic [LEN_W-1:0]     len;
    logic                 ping_hit, pong_hit;
    logic                 is_last;

    assign len      = {accum_reg[LEN_W-9:0], rx_byte};
    assign ping_hit = ping_reg && (rx_byte == ctrl_byte(1'b0, pos_reg[1:0]));
    assign pong_hit = pong_reg && (rx_byte == ctrl_byte(1'b1, pos_reg[1:0]));
    assign is_last  = (remain_reg == MAX_LEN_W'(1));

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        accum_next   = accum_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        ping_next    = ping_reg;
        pong_next    = pong_reg;
        closed_next  = closed_reg;
        push         = 1'b0;
        push_data    = '0;
        if (take && !closed_reg)
        begin
            if (remain_reg == '0)
            begin
                accum_next   = len;
                hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                if (hdr_cnt_next == HDR_CNT_W'(HEADER_BYTES) || hdr_cnt_next == '0)
                begin
                    hdr_cnt_next = '0;
                    accum_next   = '0;
                    if (len == '0)
                    begin
                        push                     = 1'b1;
                        push_data.last_of_frame  = 1'b1;
                        push_data.frame_kind     = KIND_EMPTY;
                    end
                    else if (len[LEN_W-1:MAX_LEN_W] != '0 || len[MAX_LEN_W-1:0] > max_len_reg)
                    begin
                        closed_next              = 1'b1;
                        push                     = 1'b1;
                        push_data.protocol_error = 1'b1;
                    end
                    else
                    begin
                        remain_next = len[MAX_LEN_W-1:0];
                        pos_next    = '0;
                        ping_next   = 1'b1;
                        pong_next   = 1'b1;
                    end
                end
            end
            else
            begin
                if (pos_reg < POS_SAT)
                begin
                    ping_next = ping_hit;
                    pong_next = pong_hit;
                    pos_next  = pos_reg + POS_W'(1);
                end
                remain_next              = remain_reg - MAX_LEN_W'(1);
                push                     = 1'b1;
                push_data.payload_valid  = 1'b1;
                push_data.payload_byte   = rx_byte;
                push_data.first_of_frame = (pos_reg == '0);
                push_data.last_of_frame  = is_last;
                if (is_last && pos_reg == POS_CTRL_LAST && ping_hit)
                    push_data.frame_kind = KIND_PING;
                else if (is_last && pos_reg == POS_CTRL_LAST && pong_hit)
                    push_data.frame_kind = KIND_PONG;
                else
                    push_data.frame_kind = KIND_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            hdr_cnt_reg <= '0;
            accum_reg   <= '0;
            remain_reg  <= '0;
            pos_reg     <= '0;
            ping_reg    <= 1'b0;
            pong_reg    <= 1'b0;
            closed_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
            hdr_cnt_reg <= hdr_cnt_next;
            accum_reg   <= accum_next;
            remain_reg  <= remain_next;
            pos_reg     <= pos_next;
            ping_reg    <= ping_next;
            pong_reg    <= pong_next;
            closed_reg  <= closed_next;
        end
    end

endmodule

// ----- rtl/lpd_queue.sv -----
// Two-entry result queue between the front end and the output stage.
// Uses lpd_pkg for the result type.
module lpd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpd_pkg::result_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output lpd_pkg::result_t head
);
    import lpd_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/lpd_back.sv -----
// Output stage: holds the result item on offer and refills from the queue.
// Uses lpd_pkg for the result type.
module lpd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  lpd_pkg::result_t q_head,
    output logic             q_pop,
    input  logic             out_stall,
    output logic             out_valid,
    output lpd_pkg::result_t out_data
);
    import lpd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Refill whenever the register is empty or its item leaves this cycle.
    assign q_pop     = q_not_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

endmodule

// ----- rtl/length_prefix_deframer.sv -----
// Length-prefix deframer top level: lpd_front, lpd_queue and lpd_back, using lpd_pkg.
// Throughput: one byte item per cycle, sustained, while the output side keeps up.
// Path: a result item is written into the queue at the edge that accepts its byte,
// alongside the front state update, then moves into the output register.
// Reset (rst_n, asynchronous, active low) opens the connection, clears the header
// state and the queue, and sets max_frame_length to 65536.
module length_prefix_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    // Byte input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // Configuration: the single max_frame_length register.
    input  logic                          cfg_wr_en,
    input  logic [lpd_pkg::MAX_LEN_W-1:0] cfg_wr_data,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          payload_valid,
    output logic [7:0]                    payload_byte,
    output logic                          first_of_frame,
    output logic                          last_of_frame,
    output logic [1:0]                    frame_kind,
    output logic                          protocol_error
);
    import lpd_pkg::*;

    logic    take;
    logic    push;
    result_t push_data;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    result_t q_head;
    result_t out_data;

    // The front end may produce a result on any byte, so it is held off
    // only when the queue has no free entry. Bytes that give no result
    // (header bytes, bytes after the connection closes) still need that
    // space check, which keeps the accept rule simple and timing-clean.
    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;

    lpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_data   (push_data)
    );

    // The queue decouples the front end from the output register so that a
    // stall on the result side does not stop byte intake until it fills.
    lpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    assign payload_valid  = out_data.payload_valid;
    assign payload_byte   = out_data.payload_byte;
    assign first_of_frame = out_data.first_of_frame;
    assign last_of_frame  = out_data.last_of_frame;
    assign frame_kind     = out_data.frame_kind;
    assign protocol_error = out_data.protocol_error;

endmodule
